@@ rtl/sirc_pkg.sv @@
// Shared types, constants and helpers for the pulse-width IR frame transmitter.
// Used by every module of the block; depends on nothing else.
package sirc_pkg;

   // Field widths fixed by the interface.
   localparam int KEY_CODE_W    = 7;
   localparam int DEVICE_CODE_W = 5;
   localparam int FIELD_MAX_W   = 8;

   // Default frame layout: command bits first, then address bits.
   localparam int COMMAND_BITS_DEF = 7;
   localparam int ADDRESS_BITS_DEF = 5;

   // Timer widths.
   localparam int CYCLE_W = 8;
   localparam int TICK_W  = 12;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CYCLES = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_CYCLES  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_CYCLES   = 3'd5;

   localparam logic [CYCLE_W-1:0] CARRIER_HIGH_RST = 8'd12;
   localparam logic [CYCLE_W-1:0] CARRIER_LOW_RST  = 8'd11;
   localparam logic [TICK_W-1:0]  GAP_TICKS_RST    = 12'd600;
   localparam logic [CYCLE_W-1:0] START_CYCLES_RST = 8'd96;
   localparam logic [CYCLE_W-1:0] ZERO_CYCLES_RST  = 8'd24;
   localparam logic [CYCLE_W-1:0] ONE_CYCLES_RST   = 8'd48;

   // Depth of the queue between the front and the frame engine.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_TICK,
      OP_SEND
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_BURST,
      PHASE_GAP
   } phase_type;

   typedef struct packed {
      logic                     cmd;
      logic [KEY_CODE_W-1:0]    key_code;
      logic [DEVICE_CODE_W-1:0] device_code;
   } req_type;

   typedef struct packed {
      logic led_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

   // Classified beat as it waits in the queue.
   typedef struct packed {
      op_type                   op;
      logic [KEY_CODE_W-1:0]    key_code;
      logic [DEVICE_CODE_W-1:0] device_code;
   } item_type;

   // Queue head as seen by the frame engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // A count of zero behaves as a count of one.
   function automatic logic [CYCLE_W-1:0] at_least_one(input logic [CYCLE_W-1:0] v);
      return (v == '0) ? CYCLE_W'(1) : v;
   endfunction

endpackage

@@ rtl/sirc_front.sv @@
// Input side of the IR frame transmitter: accepts request beats, classifies
// them as tick or send and holds them in a short queue. Uses sirc_pkg.
module sirc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sirc_pkg::req_type req_payload,
   output sirc_pkg::head_type head,
   input  logic              head_pop
);
   import sirc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   item_type          classified;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   // Operands of a tick beat carry no meaning and are dropped.
   always_comb begin
      classified.op          = req_payload.cmd ? OP_SEND : OP_TICK;
      classified.key_code    = req_payload.cmd ? req_payload.key_code : '0;
      classified.device_code = req_payload.cmd ? req_payload.device_code : '0;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !head_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && head_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");

   a_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with the count");

endmodule

@@ rtl/sirc_engine.sv @@
// Frame engine of the IR frame transmitter: holds the configuration registers,
// runs the burst/gap sequencer one beat per cycle while its result is not held
// by a stall, and registers each result. Uses sirc_pkg.
module sirc_engine #(
   parameter int COMMAND_BITS = sirc_pkg::COMMAND_BITS_DEF,
   parameter int ADDRESS_BITS = sirc_pkg::ADDRESS_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sirc_pkg::head_type                    head,
   output logic                                 head_pop,
   input  logic                                 csr_write_en,
   input  logic [sirc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sirc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sirc_pkg::rsp_type                     rsp_payload
);
   import sirc_pkg::*;

   localparam int FRAME_BITS  = COMMAND_BITS + ADDRESS_BITS;
   localparam int BITS_LEFT_W = $clog2(FRAME_BITS + 1);

   // Configuration registers.
   logic [CYCLE_W-1:0] carrier_high_ff, carrier_low_ff;
   logic [TICK_W-1:0]  gap_ticks_ff;
   logic [CYCLE_W-1:0] start_cycles_ff, zero_cycles_ff, one_cycles_ff;

   // Sequencer state.
   phase_type              phase_ff, phase_in;
   logic [FRAME_BITS-1:0]  frame_shift_ff, frame_shift_in;
   logic [BITS_LEFT_W-1:0] bits_left_ff, bits_left_in;
   logic [CYCLE_W-1:0]     cycle_count_ff, cycle_count_in;
   logic [TICK_W-1:0]      tick_count_ff, tick_count_in;
   logic                   carrier_on_ff, carrier_on_in;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;
   rsp_type result;

   logic                   burst_done, gap_done;
   logic [TICK_W-1:0]      tick_dec;
   logic [CYCLE_W-1:0]     cycle_dec;
   logic [FIELD_MAX_W-1:0] key_ext, dev_ext;
   logic [FRAME_BITS-1:0]  frame_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_high_ff <= CARRIER_HIGH_RST;
         carrier_low_ff  <= CARRIER_LOW_RST;
         gap_ticks_ff    <= GAP_TICKS_RST;
         start_cycles_ff <= START_CYCLES_RST;
         zero_cycles_ff  <= ZERO_CYCLES_RST;
         one_cycles_ff   <= ONE_CYCLES_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CARRIER_HIGH: carrier_high_ff <= csr_wdata[CYCLE_W-1:0];
            CSR_CARRIER_LOW:  carrier_low_ff  <= csr_wdata[CYCLE_W-1:0];
            CSR_GAP_TICKS:    gap_ticks_ff    <= csr_wdata[TICK_W-1:0];
            CSR_START_CYCLES: start_cycles_ff <= csr_wdata[CYCLE_W-1:0];
            CSR_ZERO_CYCLES:  zero_cycles_ff  <= csr_wdata[CYCLE_W-1:0];
            CSR_ONE_CYCLES:   one_cycles_ff   <= csr_wdata[CYCLE_W-1:0];
            default: ;
         endcase
      end
   end

   // A beat is taken from the queue whenever the result register can be refilled.
   assign head_pop     = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = head_pop || (rsp_valid_ff && rsp_stall);

   assign key_ext    = FIELD_MAX_W'(head.item.key_code);
   assign dev_ext    = FIELD_MAX_W'(head.item.device_code);
   assign frame_word = {dev_ext[ADDRESS_BITS-1:0], key_ext[COMMAND_BITS-1:0]};

   assign tick_dec  = (tick_count_ff != '0) ? tick_count_ff - TICK_W'(1) : tick_count_ff;
   assign cycle_dec = (cycle_count_ff != '0) ? cycle_count_ff - CYCLE_W'(1) : cycle_count_ff;

   always_comb begin
      phase_in        = phase_ff;
      frame_shift_in  = frame_shift_ff;
      bits_left_in    = bits_left_ff;
      cycle_count_in  = cycle_count_ff;
      tick_count_in   = tick_count_ff;
      carrier_on_in   = carrier_on_ff;
      result          = '0;
      burst_done      = 1'b0;
      gap_done        = 1'b0;

      if (head_pop) begin
         if (head.item.op == OP_SEND) begin
            result.busy_res = 1'b1;
            if (phase_ff == PHASE_IDLE) begin
               frame_shift_in  = frame_word;
               bits_left_in    = BITS_LEFT_W'(FRAME_BITS);
               phase_in        = PHASE_BURST;
               cycle_count_in  = at_least_one(start_cycles_ff);
               tick_count_in   = TICK_W'(at_least_one(carrier_high_ff));
               carrier_on_in   = 1'b1;
               result.accepted = 1'b1;
            end else begin
               result.led_level = (phase_ff == PHASE_BURST) && carrier_on_ff;
            end
         end else begin
            unique case (phase_ff)
               PHASE_BURST: begin
                  result.busy_res  = 1'b1;
                  result.led_level = carrier_on_ff;
                  tick_count_in    = tick_dec;
                  if (tick_dec == '0) begin
                     if (carrier_on_ff) begin
                        carrier_on_in = 1'b0;
                        tick_count_in = TICK_W'(at_least_one(carrier_low_ff));
                     end else begin
                        cycle_count_in = cycle_dec;
                        if (cycle_dec == '0) begin
                           burst_done = 1'b1;
                        end else begin
                           carrier_on_in = 1'b1;
                           tick_count_in = TICK_W'(at_least_one(carrier_high_ff));
                        end
                     end
                  end
               end
               PHASE_GAP: begin
                  result.busy_res = 1'b1;
                  tick_count_in   = tick_dec;
                  if (tick_dec == '0) begin
                     gap_done = 1'b1;
                  end
               end
               default: begin
                  phase_in       = PHASE_IDLE;
                  frame_shift_in = '0;
                  bits_left_in   = '0;
                  cycle_count_in = '0;
                  tick_count_in  = '0;
                  carrier_on_in  = 1'b0;
               end
            endcase
         end

         // End of a burst opens the gap; an empty gap closes at once.
         if (burst_done) begin
            phase_in       = PHASE_GAP;
            carrier_on_in  = 1'b0;
            cycle_count_in = '0;
            tick_count_in  = gap_ticks_ff;
            if (gap_ticks_ff == '0) begin
               gap_done = 1'b1;
            end
         end

         if (gap_done) begin
            if (bits_left_ff == '0) begin
               phase_in       = PHASE_IDLE;
               frame_shift_in = '0;
               bits_left_in   = '0;
               cycle_count_in = '0;
               tick_count_in  = '0;
               carrier_on_in  = 1'b0;
            end else begin
               frame_shift_in = frame_shift_ff >> 1;
               bits_left_in   = bits_left_ff - BITS_LEFT_W'(1);
               phase_in       = PHASE_BURST;
               cycle_count_in = at_least_one(frame_shift_ff[0] ? one_cycles_ff
                                                               : zero_cycles_ff);
               carrier_on_in  = 1'b1;
               tick_count_in  = TICK_W'(at_least_one(carrier_high_ff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_IDLE;
         frame_shift_ff <= '0;
         bits_left_ff   <= '0;
         cycle_count_ff <= '0;
         tick_count_ff  <= '0;
         carrier_on_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         frame_shift_ff <= frame_shift_in;
         bits_left_ff   <= bits_left_in;
         cycle_count_ff <= cycle_count_in;
         tick_count_ff  <= tick_count_in;
         carrier_on_ff  <= carrier_on_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_accept_starts_burst: assert property (@(posedge clock) disable iff (reset)
      head_pop && result.accepted |=> phase_ff == PHASE_BURST && carrier_on_ff)
      else $error("accepted frame did not start with a lit burst");

   a_idle_is_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_IDLE |-> bits_left_ff == '0 && !carrier_on_ff)
      else $error("idle sequencer holds frame state");

   a_burst_counters_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_BURST |-> tick_count_ff != '0 && cycle_count_ff != '0)
      else $error("burst running with an exhausted counter");

endmodule

@@ rtl/sirc_ir_frame_transmitter.sv @@
// Top level of the pulse-width IR frame transmitter: joins the request queue
// and the frame engine. Uses sirc_pkg, sirc_front and sirc_engine.
//
// Every request beat yields exactly one response beat, in order. A tick beat
// advances the frame by one timebase tick and reports the LED level for that
// tick; a send beat starts a frame when idle (accepted = 1) and is otherwise
// refused. The block sustains one beat per clock unless a response stalls: the
// engine updates its whole state for each beat it takes, and a two-entry queue
// in front keeps the input flowing while a response is held by a stall. With
// no stalls, a taken request passes its queue entry, then the result register,
// before its response is valid. The user must write configuration only while
// no beat is in flight; the block does not enforce this. A write made during a
// frame takes effect when the next burst, carrier half or gap is loaded.
module sirc_ir_frame_transmitter #(
   parameter int COMMAND_BITS = sirc_pkg::COMMAND_BITS_DEF,
   parameter int ADDRESS_BITS = sirc_pkg::ADDRESS_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sirc_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sirc_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write_en,
   input  logic [sirc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sirc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sirc_pkg::*;

   head_type head;
   logic     head_pop;

   sirc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .head_pop    (head_pop)
   );

   sirc_engine #(
      .COMMAND_BITS (COMMAND_BITS),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_pop     (head_pop),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
